// ----- sv/atot_pkg.sv -----
package atot_pkg;

	// field widths
	localparam int CW = 24;          // Q15.8 coordinate
	localparam int EW = CW + 2;      // doubled half extent
	localparam int VW = CW + 2;      // doubled vertex relative to box centre
	localparam int FW = CW + 1;      // edge vector
	localparam int NW = 80;          // normal-axis projection and radius

	localparam int QDEPTH = 2;       // work queue depth, power of two

	// cross-product component pairs: for box axis i, a = i+1 and b = i+2 (mod 3)
	localparam int unsigned AX_A [3] = '{1, 2, 0};
	localparam int unsigned AX_B [3] = '{2, 0, 1};

	typedef enum logic [2:0] {
		REG_BOX_LOW_X  = 3'd0,
		REG_BOX_LOW_Y  = 3'd1,
		REG_BOX_LOW_Z  = 3'd2,
		REG_BOX_HIGH_X = 3'd3,
		REG_BOX_HIGH_Y = 3'd4,
		REG_BOX_HIGH_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][CW-1:0] lo;
		logic [2:0][CW-1:0] hi;
	} box_t;

	// one triangle, moved to box-centred doubled coordinates
	typedef struct packed {
		logic [2:0][EW-1:0]      e;
		logic [2:0][2:0][VW-1:0] v;
		logic [2:0][2:0][FW-1:0] f;
	} derived_t;

endpackage

// ----- sv/atot_item_if.sv -----
interface atot_item_if;
	import atot_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] vert_a_x;
	logic signed [CW-1:0] vert_a_y;
	logic signed [CW-1:0] vert_a_z;
	logic signed [CW-1:0] vert_b_x;
	logic signed [CW-1:0] vert_b_y;
	logic signed [CW-1:0] vert_b_z;
	logic signed [CW-1:0] vert_c_x;
	logic signed [CW-1:0] vert_c_y;
	logic signed [CW-1:0] vert_c_z;
	logic signed [CW-1:0] shrink_amount;

	modport source (
		output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
		       vert_c_x, vert_c_y, vert_c_z, shrink_amount,
		input  ready
	);
	modport sink (
		input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
		       vert_c_x, vert_c_y, vert_c_z, shrink_amount,
		output ready
	);
endinterface

// ----- sv/atot_result_if.sv -----
interface atot_result_if;
	logic valid;
	logic ready;
	logic overlaps;

	modport source (output valid, overlaps, input ready);
	modport sink (input valid, overlaps, output ready);
endinterface

// ----- sv/atot_cfg_if.sv -----
interface atot_cfg_if;
	import atot_pkg::*;

	logic          valid;
	logic          ready;
	logic [2:0]    index;
	logic [CW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/atot_front.sv -----
module atot_front (
	atot_item_if.sink         item,
	input  atot_pkg::box_t    box,
	output atot_pkg::derived_t d
);
	import atot_pkg::*;

	logic signed [CW-1:0] vin [3][3];
	logic signed [CW-1:0] lo [3];
	logic signed [CW-1:0] hi [3];
	logic signed [EW-1:0] e [3];
	logic signed [VW-1:0] v [3][3];
	logic signed [FW-1:0] f [3][3];

	always_comb begin
		vin[0][0] = item.vert_a_x; vin[0][1] = item.vert_a_y; vin[0][2] = item.vert_a_z;
		vin[1][0] = item.vert_b_x; vin[1][1] = item.vert_b_y; vin[1][2] = item.vert_b_z;
		vin[2][0] = item.vert_c_x; vin[2][1] = item.vert_c_y; vin[2][2] = item.vert_c_z;
		for (int i = 0; i < 3; i++) begin
			lo[i] = $signed(box.lo[i]);
			hi[i] = $signed(box.hi[i]);
			e[i]  = EW'(hi[i]) - EW'(lo[i]) - (EW'(item.shrink_amount) <<< 1);
			d.e[i] = e[i];
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				v[k][i] = (VW'(vin[k][i]) <<< 1) - VW'(lo[i]) - VW'(hi[i]);
				d.v[k][i] = v[k][i];
			end
		end
		// edges: b-a, c-b, a-c (centre offset cancels)
		for (int i = 0; i < 3; i++) begin
			f[0][i] = FW'(vin[1][i]) - FW'(vin[0][i]);
			f[1][i] = FW'(vin[2][i]) - FW'(vin[1][i]);
			f[2][i] = FW'(vin[0][i]) - FW'(vin[2][i]);
			for (int m = 0; m < 3; m++)
				d.f[m][i] = f[m][i];
		end
	end
endmodule

// ----- sv/atot_queue.sv -----
module atot_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  atot_pkg::derived_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output atot_pkg::derived_t pop_data
);
	import atot_pkg::*;

	localparam int QA = $clog2(QDEPTH);

	derived_t      mem_q [QDEPTH];
	logic [QA-1:0] wr_q;
	logic [QA-1:0] rd_q;
	logic [QA:0]   cnt_q;

	assign full      = (cnt_q == (QA+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end
endmodule

// ----- sv/atot_back.sv -----
module atot_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  atot_pkg::derived_t q_data,
	output logic               q_pop,
	atot_result_if.source      result
);
	import atot_pkg::*;

	localparam int PW = VW + FW;       // vertex x edge product
	localparam int RW = EW + FW + 1;   // extent x |edge| product
	localparam int CMPW = RW + 2;      // cross-axis compare width
	localparam int HW = VW + 26;       // split normal partial product

	logic adv;

	logic signed [EW-1:0] e [3];
	logic signed [VW-1:0] v [3][3];
	logic signed [FW-1:0] f [3][3];
	logic signed [FW:0]   absf [3][3];
	logic                 box_sep;

	// stage 1
	logic                 v_s1;
	logic                 sep_s1;
	logic signed [PW-1:0] pa_s1 [3][3][3];
	logic signed [PW-1:0] pb_s1 [3][3][3];
	logic signed [RW-1:0] ra_s1 [3][3];
	logic signed [RW-1:0] rb_s1 [3][3];
	logic signed [2*FW-1:0] np_s1 [3][2];
	logic signed [VW-1:0] v0_s1 [3];
	logic signed [EW-1:0] e_s1 [3];
	// stage 2
	logic                 v_s2;
	logic                 sep_s2;
	logic signed [PW:0]   ps_s2 [3][3][3];
	logic signed [RW:0]   rs_s2 [3][3];
	logic signed [2*FW:0] n_s2 [3];
	logic signed [VW-1:0] v0_s2 [3];
	logic signed [EW-1:0] e_s2 [3];
	logic                 cross_sep;
	logic signed [2*FW:0] absn [3];
	// stage 3
	logic                 v_s3;
	logic                 sep_s3;
	logic signed [HW-1:0] ph_s3 [3];
	logic signed [HW-1:0] pl_s3 [3];
	logic signed [HW-1:0] rh_s3 [3];
	logic signed [HW-1:0] rl_s3 [3];
	// stage 4
	logic                 v_s4;
	logic                 sep_s4;
	logic signed [NW-1:0] pf_s4 [3];
	logic signed [NW-1:0] rf_s4 [3];
	// stage 5
	logic                 v_s5;
	logic                 sep_s5;
	logic signed [NW-1:0] p_s5;
	logic signed [NW-1:0] r_s5;

	logic valid_q;
	logic overlaps_q;

	assign adv          = !valid_q || result.ready;
	assign q_pop        = adv && q_valid;
	assign result.valid    = valid_q;
	assign result.overlaps = overlaps_q;

	always_comb begin
		box_sep = 1'b0;
		for (int i = 0; i < 3; i++) begin
			e[i] = $signed(q_data.e[i]);
			for (int k = 0; k < 3; k++) begin
				v[k][i]    = $signed(q_data.v[k][i]);
				f[k][i]    = $signed(q_data.f[k][i]);
				absf[k][i] = f[k][i][FW-1] ? -(FW+1)'(f[k][i]) : (FW+1)'(f[k][i]);
			end
		end
		// box axes: all projections beyond +e or all beyond -e
		for (int i = 0; i < 3; i++) begin
			if (((EW+1)'(v[0][i]) > (EW+1)'(e[i])) && ((EW+1)'(v[1][i]) > (EW+1)'(e[i]))
			    && ((EW+1)'(v[2][i]) > (EW+1)'(e[i])))
				box_sep = 1'b1;
			if (((EW+1)'(v[0][i]) < -(EW+1)'(e[i])) && ((EW+1)'(v[1][i]) < -(EW+1)'(e[i]))
			    && ((EW+1)'(v[2][i]) < -(EW+1)'(e[i])))
				box_sep = 1'b1;
		end
	end

	always_comb begin
		cross_sep = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int m = 0; m < 3; m++) begin
				if ((CMPW'(ps_s2[i][m][0]) > CMPW'(rs_s2[i][m]))
				    && (CMPW'(ps_s2[i][m][1]) > CMPW'(rs_s2[i][m]))
				    && (CMPW'(ps_s2[i][m][2]) > CMPW'(rs_s2[i][m])))
					cross_sep = 1'b1;
				if ((CMPW'(ps_s2[i][m][0]) < -CMPW'(rs_s2[i][m]))
				    && (CMPW'(ps_s2[i][m][1]) < -CMPW'(rs_s2[i][m]))
				    && (CMPW'(ps_s2[i][m][2]) < -CMPW'(rs_s2[i][m])))
					cross_sep = 1'b1;
			end
		end
		for (int j = 0; j < 3; j++)
			absn[j] = n_s2[j][2*FW] ? -n_s2[j] : n_s2[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= q_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: products
			sep_s1 <= box_sep;
			for (int i = 0; i < 3; i++) begin
				for (int m = 0; m < 3; m++) begin
					for (int k = 0; k < 3; k++) begin
						pa_s1[i][m][k] <= v[k][AX_B[i]] * f[m][AX_A[i]];
						pb_s1[i][m][k] <= v[k][AX_A[i]] * f[m][AX_B[i]];
					end
					ra_s1[i][m] <= e[AX_A[i]] * absf[m][AX_B[i]];
					rb_s1[i][m] <= e[AX_B[i]] * absf[m][AX_A[i]];
				end
				np_s1[i][0] <= f[0][AX_A[i]] * f[1][AX_B[i]];
				np_s1[i][1] <= f[0][AX_B[i]] * f[1][AX_A[i]];
				v0_s1[i]    <= v[0][i];
				e_s1[i]     <= e[i];
			end
			// s2: sums
			sep_s2 <= sep_s1;
			for (int i = 0; i < 3; i++) begin
				for (int m = 0; m < 3; m++) begin
					for (int k = 0; k < 3; k++)
						ps_s2[i][m][k] <= (PW+1)'(pa_s1[i][m][k]) - (PW+1)'(pb_s1[i][m][k]);
					rs_s2[i][m] <= (RW+1)'(ra_s1[i][m]) + (RW+1)'(rb_s1[i][m]);
				end
				n_s2[i]  <= (2*FW+1)'(np_s1[i][0]) - (2*FW+1)'(np_s1[i][1]);
				v0_s2[i] <= v0_s1[i];
				e_s2[i]  <= e_s1[i];
			end
			// s3: cross verdict, normal partial products (split at bit 25)
			sep_s3 <= sep_s2 | cross_sep;
			for (int j = 0; j < 3; j++) begin
				ph_s3[j] <= v0_s2[j] * $signed(n_s2[j][2*FW:25]);
				pl_s3[j] <= v0_s2[j] * $signed({1'b0, n_s2[j][24:0]});
				rh_s3[j] <= e_s2[j] * $signed(absn[j][2*FW:25]);
				rl_s3[j] <= e_s2[j] * $signed({1'b0, absn[j][24:0]});
			end
			// s4: recombine
			sep_s4 <= sep_s3;
			for (int j = 0; j < 3; j++) begin
				pf_s4[j] <= (NW'(ph_s3[j]) <<< 25) + NW'(pl_s3[j]);
				rf_s4[j] <= (NW'(rh_s3[j]) <<< 25) + NW'(rl_s3[j]);
			end
			// s5: normal projection and radius
			sep_s5 <= sep_s4;
			p_s5   <= pf_s4[0] + pf_s4[1] + pf_s4[2];
			r_s5   <= rf_s4[0] + rf_s4[1] + rf_s4[2];
			// output: |p| > r on the normal
			overlaps_q <= !(sep_s5 || (p_s5 > r_s5) || (p_s5 < -r_s5));
		end
	end
endmodule

// ----- sv/aabb_triangle_overlap_test.sv -----
// Channel  Dir  Payload                                         Transfer when
// item     in   vert_{a,b,c}_{x,y,z}, shrink_amount (s24 Q15.8) item.valid & item.ready
// result   out  overlaps (1 bit)                                result.valid & result.ready
// cfg      in   index (3 bits), data (24 bits)                  cfg.valid & cfg.ready
//
// One triangle per cycle sustained while the result is taken. From transfer in
// to result valid a triangle passes the queue entry written at the transfer
// edge, then five back stages and the output register.
// The rate is set by the back pipeline, which advances whenever its output
// register is empty or being taken; a two-entry queue lets the input side
// transfer up to two triangles while the output is stalled. Reset clears the box
// registers to zero and empties the queue and pipeline; cfg is always ready.
module aabb_triangle_overlap_test (
	input logic            clk,
	input logic            arst_n,
	atot_item_if.sink      item,
	atot_result_if.source  result,
	atot_cfg_if.sink       cfg
);
	import atot_pkg::*;

	box_t     box_q;
	derived_t front_d;
	derived_t queue_d;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;
	logic     push;

	// box bounds; the user must write them only while idle (the block does not enforce it)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_BOX_LOW_X:  box_q.lo[0] <= cfg.data;
				REG_BOX_LOW_Y:  box_q.lo[1] <= cfg.data;
				REG_BOX_LOW_Z:  box_q.lo[2] <= cfg.data;
				REG_BOX_HIGH_X: box_q.hi[0] <= cfg.data;
				REG_BOX_HIGH_Y: box_q.hi[1] <= cfg.data;
				REG_BOX_HIGH_Z: box_q.hi[2] <= cfg.data;
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// front: move the triangle to doubled box-centred coordinates
	atot_front u_front (
		.item (item),
		.box  (box_q),
		.d    (front_d)
	);

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	atot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_d),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (queue_d)
	);

	// back: thirteen-axis test
	atot_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (queue_d),
		.q_pop   (q_pop),
		.result  (result)
	);
endmodule
